@@ rtl/lfpd_pkg.sv @@
package lfpd_pkg;

   localparam int CHANNELS    = 8;
   localparam int SAMPLE_BITS = 12;
   localparam int CH_BITS     = $clog2(CHANNELS);

   // Datapath commands issued by the sequencer.
   localparam logic [4:0] OP_NONE  = 5'd0;
   localparam logic [4:0] OP_LOAD  = 5'd1;
   localparam logic [4:0] OP_CAL   = 5'd2;
   localparam logic [4:0] OP_DSTART = 5'd3;
   localparam logic [4:0] OP_DSTEP = 5'd4;
   localparam logic [4:0] OP_NORM  = 5'd5;
   localparam logic [4:0] OP_MAC   = 5'd6;
   localparam logic [4:0] OP_ACC   = 5'd7;
   localparam logic [4:0] OP_ERR   = 5'd8;
   localparam logic [4:0] OP_INTEG = 5'd9;
   localparam logic [4:0] OP_MULP  = 5'd10;
   localparam logic [4:0] OP_MULD  = 5'd11;
   localparam logic [4:0] OP_MULKL = 5'd12;
   localparam logic [4:0] OP_MULKH = 5'd13;
   localparam logic [4:0] OP_KI    = 5'd14;
   localparam logic [4:0] OP_SUM   = 5'd15;
   localparam logic [4:0] OP_CLAMP = 5'd16;
   localparam logic [4:0] OP_WHEEL = 5'd17;
   localparam logic [4:0] OP_OUT   = 5'd18;

   // Configuration register indexes.
   localparam logic [2:0] REG_KP     = 3'd0;
   localparam logic [2:0] REG_KI     = 3'd1;
   localparam logic [2:0] REG_KD     = 3'd2;
   localparam logic [2:0] REG_PIDLIM = 3'd3;
   localparam logic [2:0] REG_STEER  = 3'd4;
   localparam logic [2:0] REG_BASE   = 3'd5;
   localparam logic [2:0] REG_ROT    = 3'd6;
   localparam logic [2:0] REG_THR    = 3'd7;

   // Drive modes.
   localparam logic [1:0] MODE_TRACK = 2'd0;
   localparam logic [1:0] MODE_LEFT  = 2'd1;
   localparam logic [1:0] MODE_RIGHT = 2'd2;
   localparam logic [1:0] MODE_HOLD  = 2'd3;

   // Steering weights in Q.12, rightmost channel first.
   localparam logic signed [18:0] WEIGHT [CHANNELS] = '{
      -19'sd204800, -19'sd146309, -19'sd87818, -19'sd29327,
       19'sd29327,   19'sd87818,   19'sd146309,  19'sd204800
   };

   typedef struct packed {
      logic [4:0]         op;
      logic [CH_BITS-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

@@ rtl/line_follow_pid_drive.sv @@
// Line follower steering controller. A calibration item (req_tuser = 0)
// widens each channel's min/max range without a result. A control tick
// (req_tuser = 1) normalizes the eight channels one after another through a
// shared restoring divider (one quotient bit per cycle; for each channel the
// divider is loaded, run, and its quotient normalized, weighted and
// accumulated), then runs the PID and wheel steps one after another, each
// with at most one multiply: rsp_tvalid rises in the same cycle in which
// the next item can be taken. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken in, and
// that item stalls at its last step until the waiting result has been
// accepted.
module line_follow_pid_drive (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // ch0 [11:0], ch1, ch2, ch3, ch4, ch5, ch6, ch7 [95:84]
   input  logic [95:0] req_tdata,
   // kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive_mode [1:0], left_reverse [2], left_duty [9:3], right_reverse [10],
   // right_duty [17:11], pid_output [26:18], zero fill [31:27]
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import lfpd_pkg::*;

   cmd_type    cmd;
   status_type status;

   lfpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfpd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/lfpd_ctrl.sv @@
module lfpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tuser,
   output logic                 req_tready,
   input  lfpd_pkg::status_type status,
   output lfpd_pkg::cmd_type    cmd
);
   import lfpd_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CAL   = 5'd1;
   localparam logic [4:0] S_DSTART = 5'd2;
   localparam logic [4:0] S_DIV   = 5'd3;
   localparam logic [4:0] S_NORM  = 5'd4;
   localparam logic [4:0] S_MAC   = 5'd5;
   localparam logic [4:0] S_ACC   = 5'd6;
   localparam logic [4:0] S_ERR   = 5'd7;
   localparam logic [4:0] S_INTEG = 5'd8;
   localparam logic [4:0] S_MULP  = 5'd9;
   localparam logic [4:0] S_MULD  = 5'd10;
   localparam logic [4:0] S_MULKL = 5'd11;
   localparam logic [4:0] S_MULKH = 5'd12;
   localparam logic [4:0] S_KI    = 5'd13;
   localparam logic [4:0] S_SUM   = 5'd14;
   localparam logic [4:0] S_CLAMP = 5'd15;
   localparam logic [4:0] S_WHEEL = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;

   logic [4:0]         state_ff, state_in;
   logic [CH_BITS-1:0] ch_ff, ch_in;

   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ch_in      = '0;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = req_tuser ? S_DSTART : S_CAL;
            end
         end
         S_CAL: begin
            cmd.op   = OP_CAL;
            state_in = S_IDLE;
         end
         S_DSTART: begin
            cmd.op   = OP_DSTART;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DSTEP;
            if (status.div_last) state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op   = OP_NORM;
            state_in = S_MAC;
         end
         S_MAC: begin
            cmd.op   = OP_MAC;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (ch_ff == CH_BITS'(CHANNELS - 1)) begin
               state_in = S_ERR;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_DSTART;
            end
         end
         S_ERR: begin
            cmd.op   = OP_ERR;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            cmd.op   = OP_INTEG;
            state_in = S_MULP;
         end
         S_MULP: begin
            cmd.op   = OP_MULP;
            state_in = S_MULD;
         end
         S_MULD: begin
            cmd.op   = OP_MULD;
            state_in = S_MULKL;
         end
         S_MULKL: begin
            cmd.op   = OP_MULKL;
            state_in = S_MULKH;
         end
         S_MULKH: begin
            cmd.op   = OP_MULKH;
            state_in = S_KI;
         end
         S_KI: begin
            cmd.op   = OP_KI;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = S_WHEEL;
         end
         S_WHEEL: begin
            cmd.op   = OP_WHEEL;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Wait here until the result register can take the item.
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.ch = ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

@@ rtl/lfpd_dpath.sv @@
module lfpd_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  lfpd_pkg::cmd_type    cmd,
   output lfpd_pkg::status_type status,
   input  logic [lfpd_pkg::CHANNELS*lfpd_pkg::SAMPLE_BITS-1:0] req_tdata,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata
);
   import lfpd_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int DW = SB + 12;            // dividend width: |x-low| * 4096
   localparam int CW = $clog2(DW);

   // Configuration.
   logic [31:0] kp_ff, ki_ff, kd_ff;
   logic [7:0]  pidlim_ff;
   logic [6:0]  steer_ff, base_ff, rot_ff;
   logic [12:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= 32'd7851737;
         ki_ff     <= 32'd268;
         kd_ff     <= 32'd320444826;
         pidlim_ff <= 8'd160;
         steer_ff  <= 7'd90;
         base_ff   <= 7'd80;
         rot_ff    <= 7'd70;
         thr_ff    <= 13'd2048;
      end else if (csr_we) begin
         case (csr_index)
            REG_KP:     kp_ff     <= csr_wdata;
            REG_KI:     ki_ff     <= csr_wdata;
            REG_KD:     kd_ff     <= csr_wdata;
            REG_PIDLIM: pidlim_ff <= csr_wdata[7:0];
            REG_STEER:  steer_ff  <= csr_wdata[6:0];
            REG_BASE:   base_ff   <= csr_wdata[6:0];
            REG_ROT:    rot_ff    <= csr_wdata[6:0];
            REG_THR:    thr_ff    <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Samples and calibration range.
   logic [SB-1:0] samp_ff [CHANNELS];
   logic [SB-1:0] low_ff  [CHANNELS];
   logic [SB-1:0] high_ff [CHANNELS];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         for (int i = 0; i < CHANNELS; i++) samp_ff[i] <= req_tdata[i*SB +: SB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            low_ff[i]  <= '1;
            high_ff[i] <= '0;
         end
      end else if (cmd.op == OP_CAL) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (samp_ff[i] < low_ff[i])  low_ff[i]  <= samp_ff[i];
            if (samp_ff[i] > high_ff[i]) high_ff[i] <= samp_ff[i];
         end
      end
   end

   // Restoring divider, one quotient bit per cycle.
   logic signed [SB:0] num;
   logic [SB:0]        num_neg;
   logic [SB-1:0]      den;
   logic [DW-1:0]      dvd_ff, quo_ff;
   logic [SB-1:0]      den_ff, rem_ff;
   logic [CW-1:0]      cnt_ff;
   logic               neg_ff, empty_ff;
   logic [SB:0]        rem_sh;
   logic               ge;

   assign num     = $signed({1'b0, samp_ff[cmd.ch]}) - $signed({1'b0, low_ff[cmd.ch]});
   assign num_neg = -num;
   assign den     = high_ff[cmd.ch] - low_ff[cmd.ch];
   assign rem_sh  = {rem_ff, dvd_ff[DW-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DSTART) begin
         dvd_ff   <= {(num[SB] ? num_neg[SB-1:0] : num[SB-1:0]), 12'b0};
         den_ff   <= den;
         empty_ff <= high_ff[cmd.ch] <= low_ff[cmd.ch];
         neg_ff   <= num[SB];
         rem_ff   <= '0;
         quo_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.op == OP_DSTEP) begin
         rem_ff <= ge ? SB'(rem_sh - {1'b0, den_ff}) : rem_sh[SB-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
         dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.div_last = cnt_ff == CW'(DW - 1);

   // Normalize, weight and accumulate.
   logic signed [DW:0]   qs;
   logic signed [DW+1:0] val;
   logic signed [15:0]   val_sat;
   logic signed [15:0]   norm_ff [CHANNELS];
   logic signed [34:0]   prod_ff;
   logic signed [39:0]   acc_ff;

   always_comb begin
      qs  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      val = (DW+2)'(4096) - (DW+2)'(qs);
      if (val > (DW+2)'(32767))       val_sat = 16'sh7fff;
      else if (val < -(DW+2)'(32768)) val_sat = 16'sh8000;
      else                            val_sat = val[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) norm_ff[i] <= '0;
      end else if (cmd.op == OP_NORM) begin
         norm_ff[cmd.ch] <= empty_ff ? 16'sd0 : val_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MAC) prod_ff <= WEIGHT[cmd.ch] * norm_ff[cmd.ch];
      if (cmd.op == OP_LOAD)     acc_ff <= '0;
      else if (cmd.op == OP_ACC) acc_ff <= acc_ff + 40'(prod_ff);
   end

   // PID.
   logic signed [27:0] acc_sh;
   logic signed [23:0] e_ff, last_ff;
   logic signed [24:0] d_ff;
   logic signed [39:0] sum_ff;
   logic signed [40:0] sum_nx;
   logic [39:0]        sum_mag;
   logic signed [56:0] kpt_ff;
   logic signed [57:0] kdt_ff;
   logic [51:0]        kil_ff, kih_ff;
   logic [71:0]        kiprod;
   logic [58:0]        kisat;
   logic signed [60:0] kit_ff;
   logic signed [61:0] p_ff, plim;
   logic signed [45:0] pc_ff;

   assign acc_sh  = acc_ff[39:12];
   assign sum_nx  = 41'(sum_ff) + 41'(e_ff);
   assign sum_mag = sum_ff[39] ? 40'(-sum_ff) : 40'(sum_ff);
   assign kiprod  = {kih_ff, 20'b0} + {20'b0, kil_ff};
   assign kisat   = (kiprod > (72'd1 << 58)) ? (59'd1 << 58) : kiprod[58:0];
   assign plim    = $signed({18'b0, pidlim_ff, 36'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         last_ff <= '0;
      end else if (cmd.op == OP_INTEG) begin
         if (sum_nx > 41'sh7f_ffff_ffff)       sum_ff <= 40'sh7f_ffff_ffff;
         else if (sum_nx < -41'sh80_0000_0000) sum_ff <= 40'sh80_0000_0000;
         else                                  sum_ff <= sum_nx[39:0];
         last_ff <= e_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ERR: begin
            if (acc_sh > 28'sh07f_ffff)       e_ff <= 24'sh7f_ffff;
            else if (acc_sh < -28'sh080_0000) e_ff <= 24'sh80_0000;
            else                              e_ff <= acc_sh[23:0];
         end
         OP_INTEG: d_ff  <= 25'(e_ff) - 25'(last_ff);
         OP_MULP:  kpt_ff <= $signed({1'b0, kp_ff}) * e_ff;
         OP_MULD:  kdt_ff <= $signed({1'b0, kd_ff}) * d_ff;
         OP_MULKL: kil_ff <= sum_mag[19:0] * ki_ff;
         OP_MULKH: kih_ff <= sum_mag[39:20] * ki_ff;
         OP_KI:    kit_ff <= sum_ff[39] ? -$signed({2'b0, kisat}) : $signed({2'b0, kisat});
         OP_SUM:   p_ff  <= 62'(kpt_ff) + 62'(kdt_ff) + 62'(kit_ff);
         OP_CLAMP: begin
            if (p_ff > plim)       pc_ff <= plim[45:0];
            else if (p_ff < -plim) pc_ff <= 46'(-plim);
            else                   pc_ff <= p_ff[45:0];
         end
         default: ;
      endcase
   end

   // Wheel drives.
   logic signed [47:0] base_s, slim, left, right, left_c, right_c;
   logic [47:0]        left_m, right_m;
   logic [45:0]        pc_mag;
   logic [8:0]         ip;
   logic [7:0]         lpk_ff, rpk_ff;
   logic [8:0]         ip_ff;

   always_comb begin
      base_s  = $signed({4'b0, base_ff, 37'b0});
      slim    = $signed({4'b0, steer_ff, 37'b0});
      left    = base_s + 48'(pc_ff);
      right   = base_s - 48'(pc_ff);
      if (left > slim)        left_c = slim;
      else if (left < -slim)  left_c = -slim;
      else                    left_c = left;
      if (right > slim)       right_c = slim;
      else if (right < -slim) right_c = -slim;
      else                    right_c = right;
      left_m  = left_c[47]  ? 48'(-left_c)  : 48'(left_c);
      right_m = right_c[47] ? 48'(-right_c) : 48'(right_c);
      pc_mag  = pc_ff[45] ? 46'(-pc_ff) : 46'(pc_ff);
      ip      = pc_ff[45] ? -{1'b0, pc_mag[43:36]} : {1'b0, pc_mag[43:36]};
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WHEEL) begin
         lpk_ff <= {left_c[47], left_m[43:37]};
         rpk_ff <= {right_c[47], right_m[43:37]};
         ip_ff  <= ip;
      end
   end

   // Line detection, recovery and result register.
   logic signed [15:0] outer_ff [6];
   logic [15:0]        held_ff, held_nx;
   logic [1:0]         mode;
   logic signed [16:0] thr_s;
   logic               seen, lft, rgt;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   always_comb begin
      thr_s = $signed({4'b0, thr_ff});
      seen  = 1'b0;
      lft   = 1'b0;
      rgt   = 1'b0;
      for (int i = 2; i <= 5; i++) if (17'(norm_ff[i]) > thr_s) seen = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (17'(outer_ff[i]) > thr_s)     rgt = 1'b1;
         if (17'(outer_ff[3 + i]) > thr_s) lft = 1'b1;
      end
      held_nx = held_ff;
      if (seen) begin
         mode    = MODE_TRACK;
         held_nx = {lpk_ff, rpk_ff};
      end else if (rgt) begin
         mode    = MODE_RIGHT;
         held_nx = {1'b1, rot_ff, 1'b0, rot_ff};
      end else if (lft) begin
         mode    = MODE_LEFT;
         held_nx = {1'b0, rot_ff, 1'b1, rot_ff};
      end else begin
         mode    = MODE_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) outer_ff[i] <= '0;
      end else if (cmd.op == OP_OUT) begin
         held_ff      <= held_nx;
         rsp_valid_ff <= 1'b1;
         outer_ff[0]  <= norm_ff[0];
         outer_ff[1]  <= norm_ff[1];
         outer_ff[2]  <= norm_ff[2];
         outer_ff[3]  <= norm_ff[5];
         outer_ff[4]  <= norm_ff[6];
         outer_ff[5]  <= norm_ff[7];
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_data_ff <= {5'b0, ip_ff, held_nx[6:0], held_nx[7], held_nx[14:8],
                         held_nx[15], mode};
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule
